// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers on clk/rst for the transform block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define AST_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define AST_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AST_CHK(lbl, prop, msg)
`define AST_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/mvt_pkg.sv =====
// ---------------------------------------------------------------------------
// mvt_pkg
// Shared types and constants for the 4x4 matrix-vector transform.
// ---------------------------------------------------------------------------
package mvt_pkg;

  localparam int DATA_W         = 32;  // width of every payload word
  localparam int LANES          = 4;   // one lane per matrix row
  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  typedef enum logic {
    MODE_LOAD      = 1'b0,
    MODE_TRANSFORM = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                     mode;
    logic [1:0]                row;
    logic [1:0]                col;
    logic signed [DATA_W-1:0]  elem_value;
    logic signed [DATA_W-1:0]  vec_x;
    logic signed [DATA_W-1:0]  vec_y;
    logic signed [DATA_W-1:0]  vec_z;
    logic signed [DATA_W-1:0]  vec_w;
  } req_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  res_x;
    logic signed [DATA_W-1:0]  res_y;
    logic signed [DATA_W-1:0]  res_z;
    logic signed [DATA_W-1:0]  res_w;
    logic                      overflow;
  } rsp_item_t;

  // Stage load enables handed to every lane.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } stage_ctl_t;

endpackage

// ===== rtl/mvt_if.sv =====
// ---------------------------------------------------------------------------
// mvt_req_if / mvt_rsp_if
// Valid/ready channels carrying request and result items.
// ---------------------------------------------------------------------------
interface mvt_req_if;
  logic                valid;
  logic                ready;
  mvt_pkg::req_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mvt_rsp_if;
  logic                valid;
  logic                ready;
  mvt_pkg::rsp_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mvt_lane.sv =====
// ---------------------------------------------------------------------------
// mvt_lane
// One row's dot product: multiply, pair sums, total, then round/saturate.
// ---------------------------------------------------------------------------
module mvt_lane #(
  parameter int WORD_WIDTH = mvt_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  mvt_pkg::stage_ctl_t           ctl,
  input  logic signed [WORD_WIDTH-1:0]  mrow [mvt_pkg::LANES],
  input  logic signed [WORD_WIDTH-1:0]  vec  [mvt_pkg::LANES],
  output logic signed [WORD_WIDTH-1:0]  result,
  output logic                          sat
);
  import mvt_pkg::*;

  localparam int PW = 2 * WORD_WIDTH;      // one product
  localparam int SW = 2 * WORD_WIDTH + 3;  // sum of four plus rounding headroom

  localparam logic signed [SW-1:0] HALF    = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_MAX =
    {{(SW - WORD_WIDTH + 1){1'b0}}, {(WORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN =
    {{(SW - WORD_WIDTH + 1){1'b1}}, {(WORD_WIDTH - 1){1'b0}}};

  logic signed [PW-1:0]   prod [LANES];
  logic signed [PW:0]     pair_a, pair_b;
  logic signed [SW-1:0]   total;
  logic signed [SW-1:0]   rounded;
  logic signed [SW-1:0]   shifted;

  // Stage 1: four full-precision products
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      for (int c = 0; c < LANES; c++) begin
        prod[c] <= PW'(mrow[c]) * PW'(vec[c]);
      end
    end
  end

  // Stage 2: pair sums
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      pair_a <= (PW + 1)'(prod[0]) + (PW + 1)'(prod[1]);
      pair_b <= (PW + 1)'(prod[2]) + (PW + 1)'(prod[3]);
    end
  end

  // Stage 3: exact total
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      total <= SW'(pair_a) + SW'(pair_b);
    end
  end

  // Round half up, drop fraction bits, clamp to the word range
  always_comb begin
    rounded = total + HALF;
    shifted = rounded >>> FRAC_BITS;
    if (shifted > SAT_MAX) begin
      result = SAT_MAX[WORD_WIDTH-1:0];
      sat    = 1'b1;
    end else if (shifted < SAT_MIN) begin
      result = SAT_MIN[WORD_WIDTH-1:0];
      sat    = 1'b1;
    end else begin
      result = shifted[WORD_WIDTH-1:0];
      sat    = 1'b0;
    end
  end

endmodule

// ===== rtl/mvt_merge.sv =====
// ---------------------------------------------------------------------------
// mvt_merge
// Collects the four lane results and the combined flag into the output item.
// ---------------------------------------------------------------------------
module mvt_merge #(
  parameter int WORD_WIDTH = mvt_pkg::WORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,      // output register free
  input  logic                          lane_vld,  // lane stage 3 holds an item
  input  logic signed [WORD_WIDTH-1:0]  lane_res [mvt_pkg::LANES],
  input  logic [mvt_pkg::LANES-1:0]     lane_sat,
  mvt_rsp_if.source                     rsp
);
  import mvt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (take) begin
      rsp.valid <= lane_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take && lane_vld) begin
      rsp.data.res_x    <= DATA_W'(lane_res[0]);
      rsp.data.res_y    <= DATA_W'(lane_res[1]);
      rsp.data.res_z    <= DATA_W'(lane_res[2]);
      rsp.data.res_w    <= DATA_W'(lane_res[3]);
      rsp.data.overflow <= |lane_sat;
    end
  end

endmodule

// ===== rtl/matrix_vector_transform_4x4.sv =====
// ---------------------------------------------------------------------------
// matrix_vector_transform_4x4
// 4x4 signed fixed-point matrix times 4-vector, one row per lane.
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   valid/ready        mode,row,col,elem_value,vec_x..vec_w
//  rsp      out  valid/ready        res_x..res_w,overflow
//
//  One item per cycle sustained while rsp is not stalled, loads and
//  transforms alike. The accepting edge loads the products; the pair sums,
//  total and output register follow; the four row lanes run side by side.
//  Loads write the matrix at the accepting edge and give no item.
//  rst (synchronous) restores the identity matrix and empties the pipe.
//  A stalled rsp only backs up the pipe; empty stages keep accepting.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_vector_transform_4x4 #(
  parameter int WORD_WIDTH = mvt_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = mvt_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mvt_req_if.sink     req,
  mvt_rsp_if.source   rsp
);
  import mvt_pkg::*;

  localparam int N_ELEM = LANES * LANES;

  // 1.0 in the word format, or the largest word where 1.0 does not fit
  localparam logic [WORD_WIDTH-1:0] ONE = (FRAC_BITS >= WORD_WIDTH - 1) ?
    {1'b0, {(WORD_WIDTH - 1){1'b1}}} : WORD_WIDTH'(1) << FRAC_BITS;

  logic signed [WORD_WIDTH-1:0] mat [N_ELEM];   // row-major
  logic signed [WORD_WIDTH-1:0] vec [LANES];
  logic signed [WORD_WIDTH-1:0] lane_res [LANES];
  logic [LANES-1:0]             lane_sat;

  logic v1, v2, v3;          // stage occupancy
  logic rdy1, rdy2, rdy3;    // stage may load
  logic out_rdy;
  logic acc, acc_xform;
  stage_ctl_t ctl;

  // Handshake and stage flow: a stage loads when it is empty or its
  // successor is loading this cycle.
  assign out_rdy  = !rsp.valid || rsp.ready;
  assign rdy3     = !v3 || out_rdy;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign req.ready = rdy1;

  assign acc       = req.valid && req.ready;
  assign acc_xform = acc && (req.data.mode == MODE_TRANSFORM);

  assign ctl.ld1 = rdy1;
  assign ctl.ld2 = rdy2 && v1;
  assign ctl.ld3 = rdy3 && v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= acc_xform;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Matrix store; a load overwrites one element
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_ELEM; i++) begin
        mat[i] <= (i % (LANES + 1) == 0) ? ONE : '0;
      end
    end else if (acc && (req.data.mode == MODE_LOAD)) begin
      mat[{req.data.row, req.data.col}] <= req.data.elem_value[WORD_WIDTH-1:0];
    end
  end

  // Only the low word bits of each component take part
  assign vec[0] = req.data.vec_x[WORD_WIDTH-1:0];
  assign vec[1] = req.data.vec_y[WORD_WIDTH-1:0];
  assign vec[2] = req.data.vec_z[WORD_WIDTH-1:0];
  assign vec[3] = req.data.vec_w[WORD_WIDTH-1:0];

  for (genvar r = 0; r < LANES; r++) begin : g_lane
    logic signed [WORD_WIDTH-1:0] mrow [LANES];

    for (genvar c = 0; c < LANES; c++) begin : g_col
      assign mrow[c] = mat[r * LANES + c];
    end

    mvt_lane #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .mrow   (mrow),
      .vec    (vec),
      .result (lane_res[r]),
      .sat    (lane_sat[r])
    );
  end

  mvt_merge #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .take     (out_rdy),
    .lane_vld (v3),
    .lane_res (lane_res),
    .lane_sat (lane_sat),
    .rsp      (rsp)
  );

  // A transform enters stage 1, a load never does
  `AST_CHK(a_xform_enters, acc_xform |=> v1, "transform item lost at stage 1")
  `AST_CHK(a_load_no_item, (acc && !acc_xform) |=> !v1, "load item entered the pipe")
  // Nothing downstream holds, so the input side must be open
  `AST_CHK(a_ready_when_empty, !rsp.valid |-> req.ready, "input blocked with empty output")
  // Reset leaves no result pending and 1.0 in the first diagonal element
  `AST_ALWAYS(a_rst_no_item, $past(rst) |-> !rsp.valid, "result valid after reset")
  `AST_ALWAYS(a_rst_ident, $past(rst) |-> (mat[0] == ONE), "matrix not identity after reset")

endmodule
